[rtl/core/cpu65_pkg.sv]
// ----------------------------------------------------------------------------
// cpu65_pkg
// Shared types, codes and the opcode decode table for the 6502 subset core.
// ----------------------------------------------------------------------------
`default_nettype none
package cpu65_pkg;

  localparam int ADDR_BITS = 16;
  localparam int MEM_DEPTH = 1 << ADDR_BITS;

  // commands
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_EXEC  = 2'd2;
  localparam logic [1:0] CMD_VEC   = 2'd3;

  // execution status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNIMP = 2'd1;
  localparam logic [1:0] ST_UNDEF = 2'd2;

  localparam logic [15:0] RESET_VEC  = 16'hFFFC;
  localparam logic [7:0]  STACK_PAGE = 8'h01;

  // flag register bit positions
  localparam int FB_C = 0;
  localparam int FB_Z = 1;
  localparam int FB_I = 2;
  localparam int FB_D = 3;
  localparam int FB_V = 4;
  localparam int FB_N = 5;

  // instruction kinds
  localparam logic [5:0] K_UNDEF = 6'd0,  K_UNIMP = 6'd1,  K_BPL = 6'd2,  K_BMI = 6'd3,
                         K_BVC   = 6'd4,  K_BVS   = 6'd5,  K_BCC = 6'd6,  K_BCS = 6'd7,
                         K_BNE   = 6'd8,  K_BEQ   = 6'd9,  K_LDA = 6'd10, K_LDX = 6'd11,
                         K_LDY   = 6'd12, K_STA   = 6'd13, K_STX = 6'd14, K_STY = 6'd15,
                         K_PHA   = 6'd16, K_PLA   = 6'd17, K_NOP = 6'd18, K_CLC = 6'd19,
                         K_SEC   = 6'd20, K_CLI   = 6'd21, K_SEI = 6'd22, K_CLV = 6'd23,
                         K_CLD   = 6'd24, K_SED   = 6'd25, K_TSX = 6'd26, K_TXS = 6'd27,
                         K_TAX   = 6'd28, K_TXA   = 6'd29, K_TAY = 6'd30, K_TYA = 6'd31,
                         K_DEX   = 6'd32, K_INX   = 6'd33, K_DEY = 6'd34, K_INY = 6'd35,
                         K_ASL   = 6'd36, K_CMP   = 6'd37, K_CPX = 6'd38, K_CPY = 6'd39,
                         K_INC   = 6'd40, K_DEC   = 6'd41;

  // addressing modes
  localparam logic [3:0] M_IMP = 4'd0, M_ACC = 4'd1, M_IMM = 4'd2,  M_ZP  = 4'd3,
                         M_ZPX = 4'd4, M_ZPY = 4'd5, M_ABS = 4'd6,  M_ABX = 4'd7,
                         M_ABY = 4'd8, M_INX = 4'd9, M_INY = 4'd10, M_REL = 4'd11;

  // datapath operations
  localparam logic [3:0] OP_NONE = 4'd0,  OP_LATCH = 4'd1,  OP_WRITE = 4'd2,
                         OP_CAPT = 4'd3,  OP_VLO   = 4'd4,  OP_VHI   = 4'd5,
                         OP_FETCH = 4'd6, OP_DECODE = 4'd7, OP_ADDR0 = 4'd8,
                         OP_ADDR1 = 4'd9, OP_ADDR2 = 4'd10, OP_ADDR3 = 4'd11,
                         OP_ADDR4 = 4'd12, OP_EXEC = 4'd13;

  // memory address sources
  localparam logic [3:0] AS_IN  = 4'd0, AS_VLO = 4'd1, AS_VHI = 4'd2, AS_PC  = 4'd3,
                         AS_PTR = 4'd4, AS_ZPB = 4'd5, AS_ZP1 = 4'd6, AS_EA  = 4'd7,
                         AS_SP  = 4'd8, AS_SP1 = 4'd9;

  typedef struct packed {
    logic [5:0] kind;
    logic [3:0] mode;
    logic [3:0] cyc;
  } dec_t;

  typedef struct packed {
    logic [3:0] op;
    logic [3:0] addr_sel;
    logic       mem_re;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] kind;
    logic [3:0] mode;
  } dp_stat_t;

  function automatic dec_t mk(input logic [5:0] k, input logic [3:0] m,
                              input logic [3:0] c);
    dec_t d;
    d.kind = k;
    d.mode = m;
    d.cyc  = c;
    return d;
  endfunction

  function automatic dec_t decode_op(input logic [7:0] op);
    dec_t d;
    d = mk(K_UNDEF, M_IMP, 4'd0);
    case (op)
      8'h10: d = mk(K_BPL, M_REL, 4'd2);
      8'h30: d = mk(K_BMI, M_REL, 4'd2);
      8'h50: d = mk(K_BVC, M_REL, 4'd2);
      8'h70: d = mk(K_BVS, M_REL, 4'd2);
      8'h90: d = mk(K_BCC, M_REL, 4'd2);
      8'hb0: d = mk(K_BCS, M_REL, 4'd2);
      8'hd0: d = mk(K_BNE, M_REL, 4'd2);
      8'hf0: d = mk(K_BEQ, M_REL, 4'd2);
      8'ha1: d = mk(K_LDA, M_INX, 4'd6);
      8'ha5: d = mk(K_LDA, M_ZP, 4'd3);
      8'ha9: d = mk(K_LDA, M_IMM, 4'd2);
      8'had: d = mk(K_LDA, M_ABS, 4'd4);
      8'hb1: d = mk(K_LDA, M_INY, 4'd5);
      8'hb5: d = mk(K_LDA, M_ZPX, 4'd4);
      8'hb9: d = mk(K_LDA, M_ABY, 4'd4);
      8'hbd: d = mk(K_LDA, M_ABX, 4'd4);
      8'ha2: d = mk(K_LDX, M_IMM, 4'd2);
      8'ha6: d = mk(K_LDX, M_ZP, 4'd3);
      8'hae: d = mk(K_LDX, M_ABS, 4'd4);
      8'hb6: d = mk(K_LDX, M_ZPY, 4'd4);
      8'hbe: d = mk(K_LDX, M_ABY, 4'd4);
      8'ha0: d = mk(K_LDY, M_IMM, 4'd2);
      8'ha4: d = mk(K_LDY, M_ZP, 4'd3);
      8'hac: d = mk(K_LDY, M_ABS, 4'd4);
      8'hb4: d = mk(K_LDY, M_ZPX, 4'd4);
      8'hbc: d = mk(K_LDY, M_ABX, 4'd4);
      8'h48: d = mk(K_PHA, M_IMP, 4'd3);
      8'h68: d = mk(K_PLA, M_IMP, 4'd4);
      8'h81: d = mk(K_STA, M_INX, 4'd6);
      8'h85: d = mk(K_STA, M_ZP, 4'd3);
      8'h8d: d = mk(K_STA, M_ABS, 4'd4);
      8'h91: d = mk(K_STA, M_INY, 4'd6);
      8'h95: d = mk(K_STA, M_ZPX, 4'd4);
      8'h99: d = mk(K_STA, M_ABY, 4'd5);
      8'h9d: d = mk(K_STA, M_ABX, 4'd5);
      8'h86: d = mk(K_STX, M_ZP, 4'd3);
      8'h8e: d = mk(K_STX, M_ABS, 4'd4);
      8'h96: d = mk(K_STX, M_ZPY, 4'd4);
      8'h84: d = mk(K_STY, M_ZP, 4'd3);
      8'h8c: d = mk(K_STY, M_ABS, 4'd4);
      8'h94: d = mk(K_STY, M_ZPX, 4'd4);
      8'hea: d = mk(K_NOP, M_IMP, 4'd2);
      8'h18: d = mk(K_CLC, M_IMP, 4'd2);
      8'h38: d = mk(K_SEC, M_IMP, 4'd2);
      8'h58: d = mk(K_CLI, M_IMP, 4'd2);
      8'h78: d = mk(K_SEI, M_IMP, 4'd2);
      8'hb8: d = mk(K_CLV, M_IMP, 4'd2);
      8'hd8: d = mk(K_CLD, M_IMP, 4'd2);
      8'hf8: d = mk(K_SED, M_IMP, 4'd2);
      8'hba: d = mk(K_TSX, M_IMP, 4'd2);
      8'h9a: d = mk(K_TXS, M_IMP, 4'd2);
      8'haa: d = mk(K_TAX, M_IMP, 4'd2);
      8'h8a: d = mk(K_TXA, M_IMP, 4'd2);
      8'ha8: d = mk(K_TAY, M_IMP, 4'd2);
      8'h98: d = mk(K_TYA, M_IMP, 4'd2);
      8'hca: d = mk(K_DEX, M_IMP, 4'd2);
      8'he8: d = mk(K_INX, M_IMP, 4'd2);
      8'h88: d = mk(K_DEY, M_IMP, 4'd2);
      8'hc8: d = mk(K_INY, M_IMP, 4'd2);
      8'h06: d = mk(K_ASL, M_ZP, 4'd5);
      8'h0a: d = mk(K_ASL, M_ACC, 4'd2);
      8'h0e: d = mk(K_ASL, M_ABS, 4'd6);
      8'h16: d = mk(K_ASL, M_ZPX, 4'd6);
      8'h1e: d = mk(K_ASL, M_ABX, 4'd7);
      8'hc1: d = mk(K_CMP, M_INX, 4'd6);
      8'hc5: d = mk(K_CMP, M_ZP, 4'd3);
      8'hc9: d = mk(K_CMP, M_IMM, 4'd2);
      8'hcd: d = mk(K_CMP, M_ABS, 4'd4);
      8'hd1: d = mk(K_CMP, M_INY, 4'd5);
      8'hd5: d = mk(K_CMP, M_ZPX, 4'd4);
      8'hd9: d = mk(K_CMP, M_ABY, 4'd4);
      8'hdd: d = mk(K_CMP, M_ABX, 4'd4);
      8'he0: d = mk(K_CPX, M_IMM, 4'd2);
      8'he4: d = mk(K_CPX, M_ZP, 4'd3);
      8'hec: d = mk(K_CPX, M_ABS, 4'd4);
      8'hc0: d = mk(K_CPY, M_IMM, 4'd2);
      8'hc4: d = mk(K_CPY, M_ZP, 4'd3);
      8'hcc: d = mk(K_CPY, M_ABS, 4'd4);
      8'he6: d = mk(K_INC, M_ZP, 4'd5);
      8'hee: d = mk(K_INC, M_ABS, 4'd6);
      8'hf6: d = mk(K_INC, M_ZPX, 4'd6);
      8'hfe: d = mk(K_INC, M_ABX, 4'd7);
      8'hc6: d = mk(K_DEC, M_ZP, 4'd5);
      8'hce: d = mk(K_DEC, M_ABS, 4'd6);
      8'hd6: d = mk(K_DEC, M_ZPX, 4'd6);
      8'hde: d = mk(K_DEC, M_ABX, 4'd7);
      8'he1, 8'he5, 8'he9, 8'hed, 8'hf1, 8'hf5, 8'hf9, 8'hfd,
      8'h21, 8'h25, 8'h29, 8'h2d, 8'h31, 8'h35, 8'h39, 8'h3d,
      8'h41, 8'h45, 8'h49, 8'h4d, 8'h51, 8'h55, 8'h59, 8'h5d,
      8'h01, 8'h05, 8'h09, 8'h0d, 8'h11, 8'h15, 8'h19, 8'h1d,
      8'h61, 8'h65, 8'h69, 8'h6d, 8'h71, 8'h75, 8'h79, 8'h7d,
      8'h66, 8'h6a, 8'h6e, 8'h76, 8'h7e,
      8'h46, 8'h4a, 8'h4e, 8'h56, 8'h5e,
      8'h26, 8'h2a, 8'h2e, 8'h36, 8'h3e,
      8'h20, 8'h60, 8'h40, 8'h24, 8'h2c, 8'h4c, 8'h6c, 8'h00:
        d = mk(K_UNIMP, M_IMP, 4'd0);
      default: d = mk(K_UNDEF, M_IMP, 4'd0);
    endcase
    return d;
  endfunction

  // kinds that read their operand from memory
  function automatic logic needs_read(input logic [5:0] k, input logic [3:0] m);
    return (k == K_LDA) || (k == K_LDX) || (k == K_LDY) || (k == K_CMP) ||
           (k == K_CPX) || (k == K_CPY) || (k == K_INC) || (k == K_DEC) ||
           ((k == K_ASL) && (m != M_ACC));
  endfunction

endpackage
`default_nettype wire

[rtl/core/cpu65_in_if.sv]
// ----------------------------------------------------------------------------
// cpu65_in_if
// Command channel: valid/ready with command, address and data.
// ----------------------------------------------------------------------------
`default_nettype none
interface cpu65_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] mem_addr;
  logic [7:0]  mem_data;

  modport source (output valid, cmd, mem_addr, mem_data, input ready);
  modport sink   (input valid, cmd, mem_addr, mem_data, output ready);
  modport mon    (input valid, ready, cmd, mem_addr, mem_data);
endinterface
`default_nettype wire

[rtl/core/cpu65_out_if.sv]
// ----------------------------------------------------------------------------
// cpu65_out_if
// Result channel: valid/ready with the register snapshot after a transaction.
// ----------------------------------------------------------------------------
`default_nettype none
interface cpu65_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_byte;
  logic [15:0] prog_counter;
  logic [7:0]  acc_value;
  logic [7:0]  x_value;
  logic [7:0]  y_value;
  logic [7:0]  flag_bits;
  logic [3:0]  cycle_count;
  logic [1:0]  exec_status;

  modport source (output valid, read_byte, prog_counter, acc_value, x_value, y_value,
                  flag_bits, cycle_count, exec_status, input ready);
  modport sink   (input valid, read_byte, prog_counter, acc_value, x_value, y_value,
                  flag_bits, cycle_count, exec_status, output ready);
  modport mon    (input valid, ready, read_byte, prog_counter, acc_value, x_value,
                  y_value, flag_bits, cycle_count, exec_status);
endinterface
`default_nettype wire

[rtl/core/cpu6502_subset_executor_core.sv]
// ----------------------------------------------------------------------------
// cpu6502_subset_executor_core
// 6502 subset core with its own 64 KiB byte memory, one result per command.
// ----------------------------------------------------------------------------
// One command is in flight at a time. The sequencer steps a memory write,
// memory read, vector load or execute through the single memory port with
// its registered read, walking each opcode fetch, operand fetch and data
// access of an execute in turn. The result holds until taken; the next
// command is accepted in the cycle after that.
`default_nettype none
module cpu6502_subset_executor_core
  import cpu65_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  cpu65_in_if.sink    in_ch,
  cpu65_out_if.source out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cpu65_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cpu65_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_addr      (in_ch.mem_addr),
    .in_data      (in_ch.mem_data),
    .stat         (stat),
    .read_byte    (out_ch.read_byte),
    .prog_counter (out_ch.prog_counter),
    .acc_value    (out_ch.acc_value),
    .x_value      (out_ch.x_value),
    .y_value      (out_ch.y_value),
    .flag_bits    (out_ch.flag_bits),
    .cycle_count  (out_ch.cycle_count),
    .exec_status  (out_ch.exec_status)
  );

endmodule
`default_nettype wire

[rtl/core/cpu65_datapath.sv]
// ----------------------------------------------------------------------------
// cpu65_datapath
// Byte memory, 6502 registers, address formation and instruction execution.
// ----------------------------------------------------------------------------
`default_nettype none
module cpu65_datapath
  import cpu65_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  input  wire logic [15:0] in_addr,
  input  wire logic [7:0]  in_data,
  output dp_stat_t         stat,
  output logic [7:0]       read_byte,
  output logic [15:0]      prog_counter,
  output logic [7:0]       acc_value,
  output logic [7:0]       x_value,
  output logic [7:0]       y_value,
  output logic [7:0]       flag_bits,
  output logic [3:0]       cycle_count,
  output logic [1:0]       exec_status
);

  logic [7:0]  mem [MEM_DEPTH];
  logic [7:0]  rdata;

  logic [15:0] pc, ptr, ea, addr_q;
  logic [7:0]  acc, x, y, sp, tmp, tmp2, data_q, rbyte;
  logic [5:0]  flags;
  logic [3:0]  cyc;
  logic [1:0]  status;
  dec_t        dec_q, dec_now;

  logic [15:0] maddr;
  logic        we;
  logic [7:0]  wdata;
  logic [7:0]  acc_next, x_next, y_next, sp_next;
  logic [5:0]  flags_next;
  logic        take;
  logic [7:0]  shl, cmp_reg, cmp_diff;

  assign dec_now = decode_op(rdata);
  assign stat    = '{kind: dec_q.kind, mode: dec_q.mode};

  always_comb begin
    case (cmd.addr_sel)
      AS_IN:   maddr = addr_q;
      AS_VLO:  maddr = RESET_VEC;
      AS_VHI:  maddr = RESET_VEC + 16'd1;
      AS_PC:   maddr = pc;
      AS_PTR:  maddr = ptr;
      AS_ZPB:  maddr = {8'h00, rdata + ((dec_q.mode == M_INX) ? x : 8'h00)};
      AS_ZP1:  maddr = {8'h00, tmp + 8'd1};
      AS_EA:   maddr = ea;
      AS_SP:   maddr = {STACK_PAGE, sp};
      AS_SP1:  maddr = {STACK_PAGE, sp + 8'd1};
      default: maddr = ea;
    endcase
  end

  // instruction execution, operand arrives in rdata
  always_comb begin
    acc_next   = acc;
    x_next     = x;
    y_next     = y;
    sp_next    = sp;
    flags_next = flags;
    take       = 1'b0;
    wdata      = data_q;
    we         = (cmd.op == OP_WRITE);
    shl        = ((dec_q.mode == M_ACC) ? acc : rdata) << 1;
    case (dec_q.kind)
      K_CPX:   cmp_reg = x;
      K_CPY:   cmp_reg = y;
      default: cmp_reg = acc;
    endcase
    cmp_diff = cmp_reg - rdata;
    if (cmd.op == OP_EXEC) begin
      case (dec_q.kind)
        K_BPL: take = !flags[FB_N];
        K_BMI: take = flags[FB_N];
        K_BVC: take = !flags[FB_V];
        K_BVS: take = flags[FB_V];
        K_BCC: take = !flags[FB_C];
        K_BCS: take = flags[FB_C];
        K_BNE: take = !flags[FB_Z];
        K_BEQ: take = flags[FB_Z];
        K_LDA: acc_next = rdata;
        K_LDX: x_next = rdata;
        K_LDY: y_next = rdata;
        K_STA: begin we = 1'b1; wdata = acc; end
        K_STX: begin we = 1'b1; wdata = x; end
        K_STY: begin we = 1'b1; wdata = y; end
        K_PHA: begin we = 1'b1; wdata = acc; sp_next = sp - 8'd1; end
        K_PLA: begin acc_next = rdata; sp_next = sp + 8'd1; end
        K_CLC: flags_next[FB_C] = 1'b0;
        K_SEC: flags_next[FB_C] = 1'b1;
        K_CLI: flags_next[FB_I] = 1'b0;
        K_SEI: flags_next[FB_I] = 1'b1;
        K_CLV: flags_next[FB_V] = 1'b0;
        K_CLD: flags_next[FB_D] = 1'b0;
        K_SED: flags_next[FB_D] = 1'b1;
        K_TSX: x_next = sp;
        K_TXS: sp_next = x;
        K_TAX: x_next = acc;
        K_TXA: acc_next = x;
        K_TAY: y_next = acc;
        K_TYA: acc_next = y;
        K_DEX: x_next = x - 8'd1;
        K_INX: x_next = x + 8'd1;
        K_DEY: y_next = y - 8'd1;
        K_INY: y_next = y + 8'd1;
        K_ASL: begin
          flags_next[FB_C] = (dec_q.mode == M_ACC) ? acc[7] : rdata[7];
          if (dec_q.mode == M_ACC) acc_next = shl;
          else begin we = 1'b1; wdata = shl; end
        end
        K_CMP, K_CPX, K_CPY: flags_next[FB_C] = (cmp_reg >= rdata);
        K_INC: begin we = 1'b1; wdata = rdata + 8'd1; end
        K_DEC: begin we = 1'b1; wdata = rdata - 8'd1; end
        default: ;
      endcase
      // n and z follow the value each kind produces
      case (dec_q.kind)
        K_LDA, K_PLA, K_TXA, K_TYA: begin
          flags_next[FB_N] = acc_next[7]; flags_next[FB_Z] = (acc_next == 8'h00);
        end
        K_LDX, K_TSX, K_TAX, K_DEX, K_INX: begin
          flags_next[FB_N] = x_next[7]; flags_next[FB_Z] = (x_next == 8'h00);
        end
        K_LDY, K_TAY, K_DEY, K_INY: begin
          flags_next[FB_N] = y_next[7]; flags_next[FB_Z] = (y_next == 8'h00);
        end
        K_ASL: begin
          flags_next[FB_N] = shl[7]; flags_next[FB_Z] = (shl == 8'h00);
        end
        K_INC, K_DEC: begin
          flags_next[FB_N] = wdata[7]; flags_next[FB_Z] = (wdata == 8'h00);
        end
        K_CMP, K_CPX, K_CPY: begin
          flags_next[FB_N] = cmp_diff[7]; flags_next[FB_Z] = (cmp_diff == 8'h00);
        end
        default: ;
      endcase
    end
  end

  // single-port byte memory
  always_ff @(posedge clk) begin
    if (we) mem[maddr[ADDR_BITS-1:0]] <= wdata;
    if (cmd.mem_re) rdata <= mem[maddr[ADDR_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc     <= 16'h0000;
      acc    <= 8'h00;
      x      <= 8'h00;
      y      <= 8'h00;
      sp     <= 8'hFF;
      flags  <= 6'b0;
      rbyte  <= 8'h00;
      cyc    <= 4'd0;
      status <= ST_OK;
    end else begin
      case (cmd.op)
        OP_LATCH: begin
          addr_q <= in_addr;
          data_q <= in_data;
          rbyte  <= 8'h00;
          cyc    <= 4'd0;
          status <= ST_OK;
        end
        OP_CAPT: rbyte <= rdata;
        OP_VLO:  tmp <= rdata;
        OP_VHI:  pc <= {rdata, tmp};
        OP_FETCH: ptr <= pc + 16'd1;
        OP_DECODE: begin
          dec_q <= dec_now;
          if (dec_now.kind == K_UNDEF)      status <= ST_UNDEF;
          else if (dec_now.kind == K_UNIMP) status <= ST_UNIMP;
          else                              cyc <= dec_now.cyc;
        end
        OP_ADDR0: begin
          if (dec_q.mode == M_IMM) ea <= ptr;
          if ((dec_q.mode != M_IMP) && (dec_q.mode != M_ACC)) ptr <= ptr + 16'd1;
        end
        OP_ADDR1: begin
          case (dec_q.mode)
            M_ZP:  ea <= {8'h00, rdata};
            M_ZPX: ea <= {8'h00, rdata + x};
            M_ZPY: ea <= {8'h00, rdata + y};
            M_INX: tmp <= rdata + x;
            M_ABS, M_ABX, M_ABY: begin
              tmp <= rdata;
              ptr <= ptr + 16'd1;
            end
            default: tmp <= rdata;
          endcase
        end
        OP_ADDR2: begin
          case (dec_q.mode)
            M_ABX:   ea <= {rdata, tmp} + {8'h00, x};
            M_ABY:   ea <= {rdata, tmp} + {8'h00, y};
            default: ea <= {rdata, tmp};
          endcase
        end
        OP_ADDR3: tmp2 <= rdata;
        OP_ADDR4: ea <= {rdata, tmp2} + ((dec_q.mode == M_INY) ? {8'h00, y} : 16'h0000);
        OP_EXEC: begin
          acc   <= acc_next;
          x     <= x_next;
          y     <= y_next;
          sp    <= sp_next;
          flags <= flags_next;
          // tmp holds the branch displacement
          pc    <= take ? ptr + {{8{tmp[7]}}, tmp} : ptr;
          cyc   <= cyc + {3'b000, take};
        end
        default: ;
      endcase
    end
  end

  assign read_byte    = rbyte;
  assign prog_counter = pc;
  assign acc_value    = acc;
  assign x_value      = x;
  assign y_value      = y;
  assign flag_bits    = {flags[FB_N], flags[FB_V], 1'b1, 1'b0,
                         flags[FB_D], flags[FB_I], flags[FB_Z], flags[FB_C]};
  assign cycle_count  = cyc;
  assign exec_status  = status;

endmodule
`default_nettype wire

[rtl/core/cpu65_ctrl.sv]
// ----------------------------------------------------------------------------
// cpu65_ctrl
// Sequencer: steps the datapath through memory accesses for each transaction.
// ----------------------------------------------------------------------------
`default_nettype none
module cpu65_ctrl
  import cpu65_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_cmd,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_stat_t   stat,
  output dp_cmd_t         cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0,  S_WRITE  = 4'd1,  S_READ   = 4'd2,
                         S_READ_W = 4'd3,  S_VEC0   = 4'd4,  S_VEC1   = 4'd5,
                         S_VEC2   = 4'd6,  S_FETCH  = 4'd7,  S_DECODE = 4'd8,
                         S_ADDR0  = 4'd9,  S_ADDR1  = 4'd10, S_ADDR2  = 4'd11,
                         S_ADDR3  = 4'd12, S_ADDR4  = 4'd13, S_OPRD   = 4'd14,
                         S_EXEC   = 4'd15;

  logic [3:0] state, state_next;
  logic       done, done_next;

  assign in_ready  = (state == S_IDLE) && !done;
  assign out_valid = done;

  always_comb begin
    state_next = state;
    done_next  = done;
    cmd        = '{op: OP_NONE, addr_sel: AS_IN, mem_re: 1'b0};
    case (state)
      S_IDLE: begin
        if (done) begin
          if (out_ready) done_next = 1'b0;
        end else if (in_valid) begin
          cmd.op = OP_LATCH;
          case (in_cmd)
            CMD_WRITE: state_next = S_WRITE;
            CMD_READ:  state_next = S_READ;
            CMD_EXEC:  state_next = S_FETCH;
            default:   state_next = S_VEC0;
          endcase
        end
      end
      S_WRITE: begin
        cmd.op     = OP_WRITE;
        state_next = S_IDLE;
        done_next  = 1'b1;
      end
      S_READ: begin
        cmd.mem_re = 1'b1;
        state_next = S_READ_W;
      end
      S_READ_W: begin
        cmd.op     = OP_CAPT;
        state_next = S_IDLE;
        done_next  = 1'b1;
      end
      S_VEC0: begin
        cmd        = '{op: OP_NONE, addr_sel: AS_VLO, mem_re: 1'b1};
        state_next = S_VEC1;
      end
      S_VEC1: begin
        cmd        = '{op: OP_VLO, addr_sel: AS_VHI, mem_re: 1'b1};
        state_next = S_VEC2;
      end
      S_VEC2: begin
        cmd.op     = OP_VHI;
        state_next = S_IDLE;
        done_next  = 1'b1;
      end
      S_FETCH: begin
        cmd        = '{op: OP_FETCH, addr_sel: AS_PC, mem_re: 1'b1};
        state_next = S_DECODE;
      end
      S_DECODE: begin
        cmd.op     = OP_DECODE;
        state_next = S_ADDR0;
      end
      S_ADDR0: begin
        if ((stat.kind == K_UNDEF) || (stat.kind == K_UNIMP)) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end else begin
          cmd.op = OP_ADDR0;
          case (stat.mode)
            M_IMP, M_ACC: state_next = S_OPRD;
            M_IMM:        state_next = S_OPRD;
            default: begin
              cmd.addr_sel = AS_PTR;
              cmd.mem_re   = 1'b1;
              state_next   = S_ADDR1;
            end
          endcase
        end
      end
      S_ADDR1: begin
        cmd.op = OP_ADDR1;
        case (stat.mode)
          M_REL: state_next = S_EXEC;
          M_ABS, M_ABX, M_ABY: begin
            cmd.addr_sel = AS_PTR;
            cmd.mem_re   = 1'b1;
            state_next   = S_ADDR2;
          end
          M_INX, M_INY: begin
            cmd.addr_sel = AS_ZPB;
            cmd.mem_re   = 1'b1;
            state_next   = S_ADDR3;
          end
          default: state_next = S_OPRD;
        endcase
      end
      S_ADDR2: begin
        cmd.op     = OP_ADDR2;
        state_next = S_OPRD;
      end
      S_ADDR3: begin
        cmd        = '{op: OP_ADDR3, addr_sel: AS_ZP1, mem_re: 1'b1};
        state_next = S_ADDR4;
      end
      S_ADDR4: begin
        cmd.op     = OP_ADDR4;
        state_next = S_OPRD;
      end
      S_OPRD: begin
        // operand read lands in the read register for the execute step
        if (stat.kind == K_PLA) begin
          cmd.addr_sel = AS_SP1;
          cmd.mem_re   = 1'b1;
        end else if (needs_read(stat.kind, stat.mode)) begin
          cmd.addr_sel = AS_EA;
          cmd.mem_re   = 1'b1;
        end
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.op       = OP_EXEC;
        cmd.addr_sel = (stat.kind == K_PHA) ? AS_SP : AS_EA;
        state_next   = S_IDLE;
        done_next    = 1'b1;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

endmodule
`default_nettype wire

[rtl/core/cpu65_checker.sv]
// ----------------------------------------------------------------------------
// cpu65_checker
// Port-level assertions for the 6502 subset core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module cpu65_checker (
  input wire logic     clk,
  input wire logic     rst,
  cpu65_in_if.sink     in_ch,
  cpu65_out_if.source  out_ch
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped while stalled");

  // one transaction at a time
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken while a result is pending");

  a_bad_no_cycles: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.exec_status != 2'd0) |-> out_ch.cycle_count == 4'd0)
    else $error("failed opcode reports cycles");

  a_fixed_flags: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.flag_bits[5] && !out_ch.flag_bits[4])
    else $error("fixed flag bits wrong");

endmodule

bind cpu6502_subset_executor_core cpu65_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
`default_nettype wire
